// ----- rtl/core/biquad_pkg.sv -----
// Package for the biquad IIR section: beat types, register indexes, widths,
// sequencer states and the saturation helper.
// No dependencies.
package biquad_pkg;

  localparam int CHANNELS   = 3;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int NUM_COEF   = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int COEF_W     = 32;

  localparam int SAMPLE_W   = 16;
  localparam int CHAN_W     = 2;

  localparam int STATE_W    = 48;
  localparam int ACC_W      = 56;
  localparam int YFB_W      = 33;

  localparam int DIGIT_W    = 8;
  localparam int MUL_DIGITS = 5;
  localparam int B_W        = DIGIT_W * MUL_DIGITS;
  localparam int CNT_W      = $clog2(MUL_DIGITS);
  localparam int PART_W     = COEF_W + DIGIT_W + 1;
  localparam int SUM_W      = PART_W + 1;
  localparam int PROD_W     = COEF_W + B_W;

  localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(MUL_DIGITS - 1);

  localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 32'sh4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } coef_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_MUL,
    S_ACC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [CHAN_W-1:0]          channel;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [CHAN_W-1:0]          channel_out;
  } out_beat_t;

  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] hi_lim;
    logic signed [ACC_W-1:0] lo_lim;
    hi_lim = {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    lo_lim = {{(ACC_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};
    if (v > hi_lim) begin
      return hi_lim[STATE_W-1:0];
    end else if (v < lo_lim) begin
      return lo_lim[STATE_W-1:0];
    end
    return v[STATE_W-1:0];
  endfunction

endpackage

// ----- rtl/core/biquad_iir_filter.sv -----
// Biquad IIR section, transposed direct form II, shared by several channels.
// Holds the coefficient registers, per-channel delay pairs and a digit-serial multiplier.
// Depends on biquad_pkg.
//
// Usage:
//   req     : sample beat (sample_in, channel) with req_valid / req_ready.
//   rsp     : result beat (sample_out, channel_out) with rsp_valid / rsp_ready.
//   cfg     : coefficient writes (cfg_index, cfg_data), cfg_ready always high;
//             indexes 0..4 are b0, b1, b2, a1, a2 in Q2.30, others are dropped.
// Each beat runs five products through one 32 x 8 multiplier, one 8-bit digit
// of the sample or of the feedback term per cycle.
// A beat with a channel outside the configured range skips the products
// and goes from acceptance straight to the result step, which returns 0;
// the delay state stays untouched.
// The result register parts the two sides: a new beat is taken while an
// earlier result waits; a stalled receiver holds the next finished beat in
// its last step, and req_ready stays low until the result register frees.
// Reset (rst, synchronous) clears all delay terms, sets b0 to 1.0 and the
// other coefficients to 0, and empties the result register.
module biquad_iir_filter
  import biquad_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  in_beat_t             req,
  output logic                 rsp_valid,
  input  logic                 rsp_ready,
  output out_beat_t            rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data
);

  state_t state;
  state_t state_next;
  coef_idx_t op;
  coef_idx_t op_next;
  logic [CNT_W-1:0] dig_cnt;

  logic signed [COEF_W-1:0]  coef [NUM_COEF];
  logic signed [STATE_W-1:0] delay_one [CHANNELS];
  logic signed [STATE_W-1:0] delay_two [CHANNELS];

  logic signed [SAMPLE_W-1:0] x_reg;
  logic [CHAN_W-1:0]          ch_reg;
  logic                       chan_ok;
  logic [CH_IDX_W-1:0]        ch_idx;

  logic signed [SUM_W-1:0]   hi;
  logic [B_W-1:0]            lo;
  logic [B_W-1:0]            b_shift;
  logic signed [ACC_W-1:0]   acc;
  logic signed [STATE_W-1:0] y;

  logic                        chan_in_range;
  logic                        rsp_load;
  logic signed [COEF_W-1:0]    coef_sel;
  logic [DIGIT_W-1:0]          digit;
  logic signed [DIGIT_W:0]     digit_s;
  logic signed [PART_W-1:0]    partial;
  logic signed [SUM_W-1:0]     sum;
  logic signed [PROD_W-1:0]    prod;
  logic signed [PROD_W-1:0]    prod_rnd;
  logic signed [ACC_W-1:0]     prod_acc;
  logic signed [ACC_W-1:0]     fb_term;
  logic signed [ACC_W-1:0]     s1_rd;
  logic signed [ACC_W-1:0]     s2_rd;
  logic signed [STATE_W:0]     y_ext;
  logic signed [STATE_W:0]     y_out_sh;
  logic signed [STATE_W:0]     yfb_sh;
  logic signed [YFB_W-1:0]     yfb;
  logic signed [SAMPLE_W-1:0]  o_sat;

  assign cfg_ready     = 1'b1;
  assign chan_in_range = 32'(req.channel) < 32'(CHANNELS);
  assign ch_idx        = CH_IDX_W'(ch_reg);

  // digit-serial multiply: coefficient times one digit, top digit signed
  assign coef_sel = coef[op];
  assign digit    = b_shift[DIGIT_W-1:0];
  assign digit_s  = (dig_cnt == LAST_DIGIT) ? $signed({digit[DIGIT_W-1], digit})
                                            : $signed({1'b0, digit});
  assign partial  = coef_sel * digit_s;
  assign sum      = hi + partial;
  assign prod     = $signed({hi[COEF_W-1:0], lo});
  assign prod_rnd = (prod + PROD_W'(64'sd8192)) >>> 14;
  assign prod_acc = prod[ACC_W-1:0];
  assign fb_term  = prod_rnd[ACC_W-1:0];

  assign s1_rd = ACC_W'(delay_one[ch_idx]);
  assign s2_rd = ACC_W'(delay_two[ch_idx]);

  assign y_ext    = {y[STATE_W-1], y};
  assign y_out_sh = (y_ext + (STATE_W+1)'(64'sd536870912)) >>> 30;
  assign yfb_sh   = (y_ext + (STATE_W+1)'(64'sd32768)) >>> 16;
  assign yfb      = yfb_sh[YFB_W-1:0];

  always_comb begin
    if (y_out_sh > (STATE_W+1)'(64'sd32767)) begin
      o_sat = 16'sh7fff;
    end else if (y_out_sh < (STATE_W+1)'(-64'sd32768)) begin
      o_sat = 16'sh8000;
    end else begin
      o_sat = y_out_sh[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    unique case (op)
      REG_B0:  op_next = REG_B1;
      REG_B1:  op_next = REG_A1;
      REG_A1:  op_next = REG_B2;
      REG_B2:  op_next = REG_A2;
      default: op_next = REG_B0;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = chan_in_range ? S_LOAD : S_DONE;
        end
      end
      S_LOAD: state_next = S_MUL;
      S_MUL: begin
        if (dig_cnt == LAST_DIGIT) begin
          state_next = S_ACC;
        end
      end
      S_ACC: state_next = (op == REG_A2) ? S_DONE : S_LOAD;
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_ready = 1'b0;
    rsp_load  = 1'b0;
    unique case (state)
      S_IDLE:  req_ready = 1'b1;
      S_DONE:  rsp_load  = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= REG_B0;
      dig_cnt   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        op <= REG_B0;
      end else if (state == S_ACC) begin
        op <= op_next;
      end
      if (state == S_LOAD) begin
        dig_cnt <= '0;
      end else if (state == S_MUL) begin
        dig_cnt <= dig_cnt + CNT_W'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef[REG_B0] <= COEF_B0_RESET;
      coef[REG_B1] <= '0;
      coef[REG_B2] <= '0;
      coef[REG_A1] <= '0;
      coef[REG_A2] <= '0;
    end else if (cfg_valid && cfg_ready && (32'(cfg_index) < 32'(NUM_COEF))) begin
      coef[cfg_index] <= $signed(cfg_data);
    end
  end

  // delay pairs: update s1 after the a1 product, s2 after the a2 product
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        delay_one[i] <= '0;
        delay_two[i] <= '0;
      end
    end else if (state == S_ACC) begin
      if (op == REG_A1) begin
        delay_one[ch_idx] <= sat_state(acc - fb_term);
      end
      if (op == REG_A2) begin
        delay_two[ch_idx] <= sat_state(acc - fb_term);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && req_valid) begin
      x_reg   <= req.sample_in;
      ch_reg  <= req.channel;
      chan_ok <= chan_in_range;
    end
    if (state == S_LOAD) begin
      b_shift <= (op == REG_A1 || op == REG_A2) ? B_W'(yfb) : B_W'(x_reg);
      hi      <= '0;
    end
    if (state == S_MUL) begin
      hi      <= sum >>> DIGIT_W;
      lo      <= {sum[DIGIT_W-1:0], lo[B_W-1:DIGIT_W]};
      b_shift <= b_shift >> DIGIT_W;
    end
    if (state == S_ACC) begin
      unique case (op)
        REG_B0:  y   <= sat_state(prod_acc + s1_rd);
        REG_B1:  acc <= prod_acc + s2_rd;
        REG_B2:  acc <= prod_acc;
        default: ;
      endcase
    end
    if (rsp_load) begin
      rsp.sample_out  <= chan_ok ? o_sat : '0;
      rsp.channel_out <= ch_reg;
    end
  end

  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |-> (dig_cnt <= LAST_DIGIT))
    else $error("digit counter past last digit");

  a_bad_channel: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && !chan_in_range) |=> (state == S_DONE))
    else $error("out-of-range channel did not skip to result");

  a_done_after_a2: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |-> (!chan_ok || op == REG_B0))
    else $error("result reached before all five products");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && rsp_valid && !rsp_ready) |=> (state == S_DONE))
    else $error("finished beat dropped under stall");

endmodule

// ----- tb/biquad_iir_check.sv -----
// Monitor and scoreboard for the biquad IIR section: watches the cfg, req and rsp channels.
// Predicts each result from its own copy of taps and delay pairs and compares field by field.
// Depends on biquad_pkg.
module biquad_iir_check
  import biquad_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  logic                 req_ready,
  input  in_beat_t             req,
  input  logic                 rsp_valid,
  input  logic                 rsp_ready,
  input  out_beat_t            rsp,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC_BITS = 30;
  localparam int     FB_SHIFT  = 16;
  localparam int     FB_FRAC   = 14;
  localparam longint STATE_MAX = (64'sd1 <<< (STATE_W - 1)) - 1;
  localparam longint STATE_MIN = -STATE_MAX - 1;
  localparam longint OUT_MAX   = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
  localparam longint OUT_MIN   = -OUT_MAX - 1;

  logic signed [COEF_W-1:0] taps [NUM_COEF];
  longint                   s1_mem [CHANNELS];
  longint                   s2_mem [CHANNELS];
  out_beat_t                expected_q [$];
  int                       err_count = 0;

  function automatic longint clamp_state(input longint v);
    if (v > STATE_MAX) return STATE_MAX;
    if (v < STATE_MIN) return STATE_MIN;
    return v;
  endfunction

  function automatic longint round_half_up(input longint v, input int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic out_beat_t run_section(input in_beat_t b);
    out_beat_t r;
    longint    x;
    longint    y;
    longint    yfb;
    longint    o;
    longint    n1;
    longint    n2;
    int        ch;
    x = longint'($signed(b.sample_in));
    ch = int'(b.channel);
    r.channel_out = b.channel;
    r.sample_out = '0;
    if (ch >= CHANNELS) return r;
    y = clamp_state(longint'(taps[REG_B0]) * x + s1_mem[ch]);
    o = round_half_up(y, FRAC_BITS);
    if (o > OUT_MAX) o = OUT_MAX;
    if (o < OUT_MIN) o = OUT_MIN;
    yfb = round_half_up(y, FB_SHIFT);
    n1 = longint'(taps[REG_B1]) * x
         - round_half_up(longint'(taps[REG_A1]) * yfb, FB_FRAC) + s2_mem[ch];
    n2 = longint'(taps[REG_B2]) * x
         - round_half_up(longint'(taps[REG_A2]) * yfb, FB_FRAC);
    s1_mem[ch] = clamp_state(n1);
    s2_mem[ch] = clamp_state(n2);
    r.sample_out = o[SAMPLE_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      foreach (taps[i]) taps[i] = '0;
      taps[REG_B0] = COEF_B0_RESET;
      foreach (s1_mem[i]) begin
        s1_mem[i] = 0;
        s2_mem[i] = 0;
      end
      expected_q.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result beat: expected none, actual sample %0d channel %0d",
                   $time, rsp.sample_out, rsp.channel_out);
        end else begin
          want = expected_q.pop_front();
          if (rsp.sample_out !== want.sample_out) begin
            err_count++;
            $display("%0t: sample_out mismatch: expected %0d actual %0d",
                     $time, want.sample_out, rsp.sample_out);
          end
          if (rsp.channel_out !== want.channel_out) begin
            err_count++;
            $display("%0t: channel_out mismatch: expected %0d actual %0d",
                     $time, want.channel_out, rsp.channel_out);
          end
        end
      end
      if (cfg_valid && cfg_ready && cfg_index < NUM_COEF) taps[cfg_index] = cfg_data;
      if (req_valid && req_ready) expected_q.push_back(run_section(req));
    end
    pending <= expected_q.size();
    errors  <= err_count;
  end

endmodule

// ----- tb/tb_biquad_iir_filter.sv -----
// Top-level testbench for biquad_iir_filter: clock, reset, coefficient loads and sample stimulus.
// Depends on biquad_pkg, biquad_iir_filter and the biquad_iir_check scoreboard.
module tb_biquad_iir_filter
  import biquad_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT         = 1_000_000;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 250;

  localparam logic signed [SAMPLE_W-1:0] X_MAX  = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] X_MIN  = 16'sh8000;
  localparam logic [COEF_W-1:0]          C_MAX  = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0]          C_MIN  = 32'h8000_0000;
  localparam logic [COEF_W-1:0]          C_HALF = 32'h2000_0000;
  localparam logic [CHAN_W-1:0]          CH_BAD = CHAN_W'(CHANNELS);

  typedef enum int {COEF_SMALL, COEF_ANY, COEF_EDGE} coef_mode_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 req_valid = 1'b0;
  in_beat_t             req       = '0;
  logic                 rsp_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data  = '0;
  logic                 req_ready;
  logic                 rsp_valid;
  logic                 cfg_ready;
  out_beat_t            rsp;
  int                   errors;
  int                   pending;
  int unsigned          cycles    = 0;
  bit                   tx_idling = 1'b1;
  bit                   rx_idling = 1'b1;
  bit                   long_hold = 1'b0;

  biquad_iir_filter dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  biquad_iir_check check_u (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_sample(input logic signed [SAMPLE_W-1:0] x,
                             input logic [CHAN_W-1:0] ch);
    req_valid <= 1'b1;
    req <= '{sample_in: x, channel: ch};
    do @(posedge clk); while (!req_ready);
    if (tx_idling && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                            input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] a1,
                            input logic [COEF_W-1:0] a2);
    for (int k = NUM_COEF; k < 2 ** CFG_IDX_W; k++) cfg_put(CFG_IDX_W'(k), $urandom());
    cfg_put(REG_B0, b0);
    cfg_put(REG_B1, b1);
    cfg_put(REG_B2, b2);
    cfg_put(REG_A1, a1);
    cfg_put(REG_A2, a2);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    if (req_valid) req_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [COEF_W-1:0] pick_coef(input coef_mode_t mode);
    case (mode)
      COEF_SMALL: return COEF_W'(int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000);
      COEF_ANY:   return $urandom();
      default: begin
        case ($urandom_range(0, 3))
          0:       return C_MAX;
          1:       return C_MIN;
          2:       return '0;
          default: return COEF_B0_RESET;
        endcase
      end
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return X_MAX;
      1:       return X_MIN;
      2, 3, 4: return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [CHAN_W-1:0] pick_channel();
    if ($urandom_range(0, 7) == 0) return CH_BAD;
    return CHAN_W'($urandom_range(0, CHANNELS - 1));
  endfunction

  initial begin
    @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_idling && $urandom_range(0, 3) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    coef_mode_t mode;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    push_sample(X_MAX, 0);
    push_sample(X_MIN, 1);
    push_sample(0, 2);
    push_sample(1, 0);
    push_sample(-1, 1);
    push_sample(X_MAX, CH_BAD);
    wait_idle();

    // drive the delay terms into saturation
    load_coefs(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN);
    repeat (4) push_sample(X_MAX, 0);
    repeat (3) push_sample(X_MIN, 1);
    push_sample(X_MIN, 2);
    push_sample(0, 2);
    wait_idle();

    // half-way products land on rounding ties
    load_coefs(C_HALF, C_MIN, C_HALF, C_HALF, C_MAX);
    push_sample(1, 0);
    push_sample(-1, 0);
    push_sample(3, 1);
    push_sample(-3, 1);
    push_sample(X_MIN, 2);
    push_sample(X_MAX, 2);
    push_sample(5, CH_BAD);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mode = (p % 4 == 1) ? COEF_ANY : (p % 4 == 3) ? COEF_EDGE : COEF_SMALL;
      load_coefs(pick_coef(mode), pick_coef(mode), pick_coef(mode),
                 pick_coef(mode), pick_coef(mode));
      if (p == 1) long_hold = 1'b1;
      if (p == RANDOM_PHASES - 1) begin
        tx_idling = 1'b0;
        rx_idling = 1'b0;
      end
      repeat (PHASE_ITEMS) push_sample(pick_sample(), pick_channel());
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
